[sv/md5sh_pkg.sv]
// md5sh_pkg: shared types, tables and helper functions of the MD5 stream hasher.
// Used by md5sh_ctrl, md5sh_datapath and md5_stream_hasher; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package md5sh_pkg;

  // Input request: one message byte and/or an end-of-message mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       finish;
  } req_t;

  // Output item: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_t;

  // Source of a message memory write issued by the controller
  typedef enum logic [1:0] {
    WR_HEAD   = 2'd0,
    WR_ZERO   = 2'd1,
    WR_LEN_LO = 2'd2,
    WR_LEN_HI = 2'd3
  } wr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept_byte;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic [3:0] wr_addr;
    logic       rd_en;
    logic [5:0] rd_round;
    logic [5:0] rnd;
    logic       init_work;
    logic       do_round;
    logic       update_chain;
    logic       load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [3:0] pos_word;
    logic       block_full;
    logic       out_busy;
  } status_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned NUM_WORDS  = 16;

  localparam logic [3:0] LAST_PAD_WORD = 4'd13;
  localparam logic [3:0] LEN_LO_WORD   = 4'd14;
  localparam logic [3:0] LEN_HI_WORD   = 4'd15;
  localparam logic [5:0] LAST_ROUND    = 6'd63;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = r[3:0];
    case (r[5:4])
      2'd0:    g = i4;
      2'd1:    g = (i4 << 2) + i4 + 4'd1;
      2'd2:    g = (i4 << 1) + i4 + 4'd5;
      2'd3:    g = (i4 << 3) - i4;
      default: g = i4;
    endcase
    return g;
  endfunction

  // Left rotate by a variable amount
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] x;
    x = {v, v} << n;
    return x[63:32];
  endfunction

  // Last partial word of a message: k collected bytes sit in the top of asm
  function automatic logic [31:0] pad_head(input logic [31:0] asm, input logic [1:0] k);
    logic [31:0] w;
    case (k)
      2'd0:    w = 32'h0000_0080;
      2'd1:    w = {16'h0000, 8'h80, asm[31:24]};
      2'd2:    w = {8'h00, 8'h80, asm[31:16]};
      2'd3:    w = {8'h80, asm[31:8]};
      default: w = 32'h0000_0080;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/md5_stream_hasher.sv]
// MD5 stream hasher: takes one request per item (a message byte, an end mark,
// or both) and returns the 128-bit digest as four 32-bit words A, B, C, D,
// each word's bytes in little-endian order, the last one marked. A byte that
// does not complete a 64-byte block leaves the hasher ready for the next
// request. The byte that completes a block starts a compression (a load step,
// 64 rounds through a single round unit fed by a 16-word message memory, a
// chaining update) during which no request is taken. An end mark leads to
// padding of each word left in the block, one compression and a load of the
// output buffer; when fewer than nine bytes of room are left, the length goes
// into a second block, which adds padding of all sixteen words and a second
// compression. The digest sits in an output buffer, so the next message may
// begin while it drains; a second digest waits until the first has gone.
// Depends on md5sh_pkg, md5sh_ctrl and md5sh_datapath.
`timescale 1ns / 1ps
`default_nettype none

module md5_stream_hasher (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire md5sh_pkg::req_t    req,
  output logic                    digest_valid,
  input  wire logic               digest_ready,
  output md5sh_pkg::digest_t      digest
);
  import md5sh_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  md5sh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .byte_present (req.byte_present),
    .finish       (req.finish),
    .req_ready    (req_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Storage, round unit and digest buffer
  md5sh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (req.data_byte),
    .status       (status),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule

`default_nettype wire

[sv/md5sh_ctrl.sv]
// md5sh_ctrl: sequencer of the MD5 stream hasher (byte intake, padding,
// 64-round compression, digest hand-off). Depends on md5sh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5sh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              byte_present,
  input  wire logic              finish,
  output logic                   req_ready,
  input  wire md5sh_pkg::status_t status,
  output md5sh_pkg::cmd_t        cmd
);
  import md5sh_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_LOAD     = 9'b000000010,
    ST_ROUND    = 9'b000000100,
    ST_UPDATE   = 9'b000001000,
    ST_PAD_HEAD = 9'b000010000,
    ST_PAD_ZERO = 9'b000100000,
    ST_LEN_LO   = 9'b001000000,
    ST_LEN_HI   = 9'b010000000,
    ST_OUT_WAIT = 9'b100000000
  } state_t;

  // Where to go once a compression finishes
  typedef enum logic [1:0] {
    AFT_IDLE = 2'd0,
    AFT_PAD  = 2'd1,
    AFT_ZERO = 2'd2,
    AFT_EMIT = 2'd3
  } after_t;

  state_t     state, state_next;
  after_t     after, after_next;
  logic [5:0] rnd, rnd_next;
  logic [3:0] ptr, ptr_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    after_next = after;
    rnd_next   = rnd;
    ptr_next   = ptr;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.wr_sel = WR_ZERO;
    cmd.rnd    = rnd;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept_byte = byte_present;
          if (byte_present && status.block_full) begin
            after_next = finish ? AFT_PAD : AFT_IDLE;
            state_next = ST_LOAD;
          end else if (finish) begin
            state_next = ST_PAD_HEAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_round  = '0;
        cmd.init_work = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_round = rnd + 6'd1;
        rnd_next     = rnd + 6'd1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update_chain = 1'b1;
        case (after)
          AFT_IDLE: state_next = ST_IDLE;
          AFT_PAD:  state_next = ST_PAD_HEAD;
          AFT_ZERO: begin
            ptr_next   = '0;
            state_next = ST_PAD_ZERO;
          end
          AFT_EMIT: state_next = ST_OUT_WAIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PAD_HEAD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_HEAD;
        ptr_next   = status.pos_word + 4'd1;
        if (status.pos_word == LEN_HI_WORD) begin
          after_next = AFT_ZERO;
          state_next = ST_LOAD;
        end else if (status.pos_word == LAST_PAD_WORD) begin
          state_next = ST_LEN_LO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_ZERO;
        cmd.wr_addr = ptr;
        ptr_next    = ptr + 4'd1;
        if (ptr == LEN_HI_WORD) begin
          after_next = AFT_ZERO;
          state_next = ST_LOAD;
        end else if (ptr == LAST_PAD_WORD) begin
          state_next = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_LEN_LO;
        cmd.wr_addr = LEN_LO_WORD;
        state_next  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_LEN_HI;
        cmd.wr_addr = LEN_HI_WORD;
        after_next  = AFT_EMIT;
        state_next  = ST_LOAD;
      end
      ST_OUT_WAIT: begin
        // Hold the digest until the previous one has fully drained
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      after <= AFT_IDLE;
      rnd   <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      after <= after_next;
      rnd   <= rnd_next;
      ptr   <= ptr_next;
    end
  end

endmodule

`default_nettype wire

[sv/md5sh_datapath.sv]
// md5sh_datapath: message word memory, byte counter, MD5 round unit, chaining
// words and digest output buffer. Driven by md5sh_ctrl; depends on md5sh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5sh_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire md5sh_pkg::cmd_t    cmd,
  input  wire logic [7:0]         data_byte,
  output md5sh_pkg::status_t      status,
  output logic                    digest_valid,
  input  wire logic               digest_ready,
  output md5sh_pkg::digest_t      digest
);
  import md5sh_pkg::*;

  logic [31:0] mem [NUM_WORDS];
  logic [31:0] mem_q;
  logic [31:0] asm_word;
  logic [63:0] byte_count;
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] obuf [4];
  logic [2:0]  out_cnt;
  logic [1:0]  out_idx;

  logic        byte_wr;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [31:0] byte_word;
  logic [63:0] bit_len;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] b_new;
  logic        out_take;

  assign byte_word = {data_byte, asm_word[31:8]};
  assign byte_wr   = cmd.accept_byte && (byte_count[1:0] == 2'd3);
  assign bit_len   = {byte_count[60:0], 3'b000};

  // Select the memory write source
  always_comb begin
    mem_we = byte_wr || cmd.wr_en;
    mem_wa = cmd.wr_addr;
    mem_wd = '0;
    if (byte_wr) begin
      mem_wa = byte_count[5:2];
      mem_wd = byte_word;
    end else begin
      case (cmd.wr_sel)
        WR_HEAD: begin
          mem_wa = byte_count[5:2];
          mem_wd = pad_head(asm_word, byte_count[1:0]);
        end
        WR_ZERO:   mem_wd = '0;
        WR_LEN_LO: mem_wd = bit_len[31:0];
        WR_LEN_HI: mem_wd = bit_len[63:32];
        default:   mem_wd = '0;
      endcase
    end
  end

  // Message word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[msg_index(cmd.rd_round)];
    end
  end

  // Assemble bytes into little-endian words
  always_ff @(posedge clk) begin
    if (cmd.accept_byte) begin
      asm_word <= byte_word;
    end
  end

  // One MD5 round
  always_comb begin
    case (cmd.rnd[5:4])
      2'd0:    f = (wb & wc) | (~wb & wd);
      2'd1:    f = (wb & wd) | (wc & ~wd);
      2'd2:    f = wb ^ wc ^ wd;
      2'd3:    f = wc ^ (wb | ~wd);
      default: f = wb ^ wc ^ wd;
    endcase
    t     = wa + f + mem_q + ROUND_K[cmd.rnd];
    b_new = wb + rotl32(t, ROT_AMT[{cmd.rnd[5:4], cmd.rnd[1:0]}]);
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.init_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (cmd.do_round) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= b_new;
    end
  end

  // Chaining words and byte counter; reload the initial state after a digest
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      for (int i = 0; i < 4; i++) begin
        chain[i] <= CHAIN_IV[i];
      end
      byte_count <= '0;
    end else begin
      if (cmd.update_chain) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
      if (cmd.accept_byte) begin
        byte_count <= byte_count + 64'd1;
      end
    end
  end

  // Digest buffer: shift out one word per accepted result
  assign out_take = digest_valid && digest_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < 4; i++) begin
        obuf[i] <= chain[i];
      end
    end else if (out_take) begin
      obuf[0] <= obuf[1];
      obuf[1] <= obuf[2];
      obuf[2] <= obuf[3];
      obuf[3] <= obuf[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
      out_idx <= '0;
    end else if (cmd.load_out) begin
      out_cnt <= 3'd4;
      out_idx <= '0;
    end else if (out_take) begin
      out_cnt <= out_cnt - 3'd1;
      out_idx <= out_idx + 2'd1;
    end
  end

  assign digest_valid       = (out_cnt != 3'd0);
  assign digest.digest_word = obuf[0];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == 2'd3);

  assign status.pos_word   = byte_count[5:2];
  assign status.block_full = (byte_count[5:0] == 6'd63);
  assign status.out_busy   = digest_valid;

endmodule

`default_nettype wire
